FILE: rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame deframer: parser phases,
// configuration register indexes and reset values, and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // byte width of the configuration and result byte fields
    localparam int unsigned ByteW = 8;

    // configuration port
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_VALUE    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_ID        = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SECOND_ID       = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_FUNCTION  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SECOND_FUNCTION = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_LENGTH_LIMIT    = 3'd5;

    // register values after reset
    localparam logic [ByteW-1:0] RST_HEADER_VALUE    = 8'hAA;
    localparam logic [ByteW-1:0] RST_FIRST_ID        = 8'h29;
    localparam logic [ByteW-1:0] RST_SECOND_ID       = 8'h30;
    localparam logic [ByteW-1:0] RST_FIRST_FUNCTION  = 8'h05;
    localparam logic [ByteW-1:0] RST_SECOND_FUNCTION = 8'hA4;
    localparam logic [ByteW-1:0] RST_LENGTH_LIMIT    = 8'd50;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ID      = 3'd1,
        PH_FUNC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TRAILER = 3'd5
    } phase_t;

    // configuration register set
    typedef struct packed {
        logic [ByteW-1:0] header_value;
        logic [ByteW-1:0] first_id;
        logic [ByteW-1:0] second_id;
        logic [ByteW-1:0] first_function;
        logic [ByteW-1:0] second_function;
        logic [ByteW-1:0] length_limit;
    } cfg_t;

    // one result transaction
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic [ByteW-1:0] frame_id;
        logic [ByteW-1:0] function_code;
        logic [ByteW-1:0] byte_index;
        logic             last;
    } result_t;

endpackage

FILE: rtl/core/sfd_rx_if.sv
// ----------------------------------------------------------------------------
// sfd_rx_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface sfd_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

FILE: rtl/core/sfd_res_if.sv
// ----------------------------------------------------------------------------
// sfd_res_if
// Result channel: valid/ready handshake carrying one payload or trailer byte
// together with the frame id, function code, index and last flag.
// ----------------------------------------------------------------------------
interface sfd_res_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] frame_id;
    logic [7:0] function_code;
    logic [7:0] byte_index;
    logic       last;

    modport source (
        output valid, output data_byte, output frame_id, output function_code,
        output byte_index, output last, input ready
    );
    modport sink (
        input valid, input data_byte, input frame_id, input function_code,
        input byte_index, input last, output ready
    );

endinterface

FILE: rtl/core/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// Frame parser state machine. On each step it consumes one byte, updates
// phase and frame context, and flags whether the byte yields a result.
// ----------------------------------------------------------------------------
module sfd_parser
    import sfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [ByteW-1:0] rx_byte,
    input  cfg_t             cfg,
    output logic             emit,
    output result_t          result
);

    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] remaining_reg, remaining_next;
    logic [ByteW-1:0] position_reg, position_next;
    logic [ByteW-1:0] held_id_reg, held_id_next;
    logic [ByteW-1:0] held_function_reg, held_function_next;

    logic id_match;
    logic func_match;
    logic len_ok;
    logic [ByteW-1:0] remaining_dec;

    // byte checks against the configured values
    assign id_match      = (rx_byte == cfg.first_id) || (rx_byte == cfg.second_id);
    assign func_match    = (rx_byte == cfg.first_function)
                        || (rx_byte == cfg.second_function);
    assign len_ok        = (rx_byte < cfg.length_limit);
    assign remaining_dec = remaining_reg - 8'd1;

    // next state and frame context
    always_comb
    begin
        phase_next         = phase_reg;
        remaining_next     = remaining_reg;
        position_next      = position_reg;
        held_id_next       = held_id_reg;
        held_function_next = held_function_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    phase_next = (rx_byte == cfg.header_value) ? PH_ID : PH_HUNT;
                end
                PH_ID:
                begin
                    if (id_match)
                    begin
                        held_id_next = rx_byte;
                        phase_next   = PH_FUNC;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_FUNC:
                begin
                    if (func_match)
                    begin
                        held_function_next = rx_byte;
                        phase_next         = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN:
                begin
                    if (len_ok)
                    begin
                        remaining_next = rx_byte;
                        position_next  = '0;
                        phase_next     = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (remaining_reg != '0)
                    begin
                        remaining_next = remaining_dec;
                        position_next  = position_reg + 8'd1;
                        phase_next     = (remaining_dec == '0) ? PH_TRAILER : PH_PAYLOAD;
                    end
                    else
                    begin
                        // zero-length frame: byte is dropped silently
                        phase_next = PH_HUNT;
                    end
                end
                PH_TRAILER:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // result generation
    always_comb
    begin
        emit                 = 1'b0;
        result.data_byte     = rx_byte;
        result.frame_id      = held_id_reg;
        result.function_code = held_function_reg;
        result.byte_index    = position_reg;
        result.last          = 1'b0;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                emit = step && (remaining_reg != '0);
            end
            PH_TRAILER:
            begin
                emit        = step;
                result.last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            remaining_reg     <= '0;
            position_reg      <= '0;
            held_id_reg       <= '0;
            held_function_reg <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            remaining_reg     <= remaining_next;
            position_reg      <= position_next;
            held_id_reg       <= held_id_next;
            held_function_reg <= held_function_next;
        end
    end

endmodule

FILE: rtl/core/serial_frame_deframer.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Parses header / id / function / length / payload / trailer frames from a
// received byte stream and streams payload and trailer bytes out.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle, sustained, as long as the result
// side keeps tx.ready high; while a pending result is held off, the captured
// byte waits and the input stalls once the input register is full. A byte is
// first captured in an input register, then handled by the parser state
// machine once the output register can take a result; the parser writes any
// result into the output register, which presents it on tx. Payload bytes
// come out with last low, the trailer byte with last high; header, id,
// function code and length bytes, every mismatching byte and the byte after
// a zero length value produce nothing. Configuration registers are written
// through cfg_we / cfg_index / cfg_data and should only change while no
// frame is in flight.
module serial_frame_deframer
    import sfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [ByteW-1:0]   cfg_data,
    sfd_rx_if.sink             rx,
    sfd_res_if.source          tx
);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             advance;
    logic             emit;
    result_t          result;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value    <= RST_HEADER_VALUE;
            cfg_reg.first_id        <= RST_FIRST_ID;
            cfg_reg.second_id       <= RST_SECOND_ID;
            cfg_reg.first_function  <= RST_FIRST_FUNCTION;
            cfg_reg.second_function <= RST_SECOND_FUNCTION;
            cfg_reg.length_limit    <= RST_LENGTH_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_VALUE:    cfg_reg.header_value    <= cfg_data;
                CFG_FIRST_ID:        cfg_reg.first_id        <= cfg_data;
                CFG_SECOND_ID:       cfg_reg.second_id       <= cfg_data;
                CFG_FIRST_FUNCTION:  cfg_reg.first_function  <= cfg_data;
                CFG_SECOND_FUNCTION: cfg_reg.second_function <= cfg_data;
                CFG_LENGTH_LIMIT:    cfg_reg.length_limit    <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // the captured byte moves on when the output register can take a result
    assign advance  = in_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // frame parser
    sfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    // result transaction
    assign tx.valid         = out_valid_reg;
    assign tx.data_byte     = out_reg.data_byte;
    assign tx.frame_id      = out_reg.frame_id;
    assign tx.function_code = out_reg.function_code;
    assign tx.byte_index    = out_reg.byte_index;
    assign tx.last          = out_reg.last;

endmodule
